// ===== hw/rtl/pfgr_pkg.sv =====
// Shared constants, types and the glyph font for the page framebuffer renderer.
// Depends on nothing; the renderer and the checker refer to it by scoped names.
`default_nettype none

package pfgr_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int MAX_SCALE     = 8;

   localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = PAGES * SCREEN_WIDTH;
   localparam int ADDR_BITS   = $clog2(STORE_BYTES);
   localparam int PAGE_BITS   = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int X_BITS      = $clog2(SCREEN_WIDTH);
   localparam int SCALE_BITS  = $clog2(MAX_SCALE + 1);
   localparam int COORD_BITS  = 11;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam logic [2:0] KIND_PIXEL      = 3'd0;
   localparam logic [2:0] KIND_GLYPH      = 3'd1;
   localparam logic [2:0] KIND_LINE       = 3'd2;
   localparam logic [2:0] KIND_CLEAR_RECT = 3'd3;
   localparam logic [2:0] KIND_CLEAR_ALL  = 3'd4;
   localparam logic [2:0] KIND_PLOT       = 3'd5;
   localparam logic [2:0] KIND_READ       = 3'd6;

   localparam int PLOT_MID  = 32;
   localparam int PLOT_DIV  = 20;
   localparam int PLOT_LOW  = 10;
   localparam int PLOT_HIGH = 54;
   localparam int PLOT_RECIP = (65536 + PLOT_DIV - 1) / PLOT_DIV;
   localparam logic signed [15:0] PLOT_HI_LIMIT = 16'((PLOT_HIGH - PLOT_MID) * PLOT_DIV);
   localparam logic signed [15:0] PLOT_LO_LIMIT = 16'((PLOT_MID - PLOT_LOW) * PLOT_DIV);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam int         DASH_ROW   = 3;
   localparam logic [7:0] BOX_EDGE_COL = 8'h7F;
   localparam logic [7:0] BOX_MID_COL  = 8'h41;

   localparam logic [6:0] DIGIT_FONT [10][5] = '{
      '{7'd62, 7'd81, 7'd73, 7'd69, 7'd62},
      '{7'd0, 7'd66, 7'd127, 7'd64, 7'd0},
      '{7'd66, 7'd97, 7'd81, 7'd73, 7'd70},
      '{7'd33, 7'd65, 7'd69, 7'd75, 7'd49},
      '{7'd24, 7'd20, 7'd18, 7'd127, 7'd16},
      '{7'd39, 7'd69, 7'd69, 7'd69, 7'd57},
      '{7'd60, 7'd74, 7'd73, 7'd73, 7'd48},
      '{7'd1, 7'd113, 7'd9, 7'd5, 7'd3},
      '{7'd54, 7'd73, 7'd73, 7'd73, 7'd54},
      '{7'd6, 7'd73, 7'd73, 7'd41, 7'd30}
   };

   // Bit b of the result is font row b of font column col of the glyph.
   function automatic logic [7:0] glyph_column(input logic [7:0] code, input logic [2:0] col);
      logic [7:0] bits;
      logic [3:0] digit;
      bits  = '0;
      digit = 4'(code - CHAR_ZERO);
      if (col <= 3'd4) begin
         if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            bits = {1'b0, DIGIT_FONT[digit][col]};
         end else if (code == CHAR_DASH) begin
            bits = 8'(1) << DASH_ROW;
         end else if (code == CHAR_SPACE) begin
            bits = '0;
         end else if (col == 3'd0 || col == 3'd4) begin
            bits = BOX_EDGE_COL;
         end else begin
            bits = BOX_MID_COL;
         end
      end
      return bits;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfgr_if.sv =====
// Valid/ready channel interfaces for the command and read-back items.
// Depends on nothing but the field widths of the command set.
`default_nettype none

interface pfgr_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic signed [8:0] pos_x;
   logic signed [8:0] pos_y;
   logic signed [8:0] end_x;
   logic [7:0]        width;
   logic [7:0]        height;
   logic [7:0]        char_code;
   logic [3:0]        scale;
   logic signed [15:0] sample_value;
   logic [9:0]        read_index;

   modport source (output valid, kind, pos_x, pos_y, end_x, width, height, char_code,
                   scale, sample_value, read_index, input ready);
   modport sink (input valid, kind, pos_x, pos_y, end_x, width, height, char_code,
                 scale, sample_value, read_index, output ready);
endinterface

interface pfgr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/page_framebuffer_glyph_renderer.sv =====
// Monochrome page-layout framebuffer with a pixel, line, rectangle, glyph and plot engine.
// Uses pfgr_pkg for constants and font, and pfgr_req_if / pfgr_rsp_if for its channels.
//
// The req channel carries one drawing or read command per item; the rsp channel returns
// one byte for each read command and nothing for the others. The framebuffer lives in a
// single synchronous RAM of one byte per page column.
// A drawing command walks its area page by page: a row pass over the pixel rows
// (for a glyph, from its top row even above the screen) fills a row mask, then a column
// pass over the columns (for a glyph, from its left column) reads each byte and
// writes it back modified in the following cycle.
// A command that touches no pixel on screen, and an unknown kind, leave the block idle.
// A read goes through the READ and RESP states to the result register.
// The block takes one item at a time; req.ready is high only while it is idle.
// A pending result waits in the output register while new items are accepted; a read
// behind it waits until the receiver takes the earlier result.
// After reset the block clears every framebuffer byte, one byte a cycle, with req.ready
// low, then becomes ready.
`default_nettype none

module page_framebuffer_glyph_renderer (
   input  wire logic   clock,
   input  wire logic   reset,
   pfgr_req_if.sink    req,
   pfgr_rsp_if.source  rsp
);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_ROWS, S_COLS, S_DRAIN, S_READ, S_RESP
   } state_type;

   typedef pfgr_pkg::coord_type coord_type;

   localparam int AB = pfgr_pkg::ADDR_BITS;
   localparam int PB = pfgr_pkg::PAGE_BITS;
   localparam int SB = pfgr_pkg::SCALE_BITS;

   state_type              state_ff, state_in;
   logic [AB-1:0]          init_cnt_ff, init_cnt_in;
   coord_type              y_ff, y_in, y_hi_ff, y_hi_in;
   coord_type              x_ff, x_in, x_lo_ff, x_lo_in, x_hi_ff, x_hi_in;
   logic [2:0]             fr_ff, fr_in, a_ff, a_in;
   logic [SB-1:0]          fsub_ff, fsub_in, asub_ff, asub_in, scale_ff, scale_in;
   logic [PB-1:0]          page_ff, page_in;
   logic                   rows_done_ff, rows_done_in;
   logic                   glyph_ff, glyph_in, set_ff, set_in;
   logic [7:0]             code_ff, code_in;
   logic [7:0]             rowmask_ff, rowmask_in;
   logic [7:0][2:0]        rowfr_ff, rowfr_in;
   logic [9:0]             rdidx_ff, rdidx_in;
   logic                   rd_oob_ff, rd_oob_in;
   logic                   wv_ff, wv_in, wset_ff, wset_in;
   logic [AB-1:0]          wa_ff, wa_in;
   logic [7:0]             wm_ff, wm_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff, rsp_data_in;

   logic [7:0]             mem [pfgr_pkg::STORE_BYTES];
   logic [7:0]             rd_data_ff;
   logic [AB-1:0]          mem_ra, mem_wa, col_addr;
   logic                   mem_we;
   logic [7:0]             mem_wd;

   coord_type              px, py, ex, dx_lo, dx_hi, dy_lo, dy_hi, plot_row, z5, z7;
   logic [4:0]             scale_w;
   logic [SB-1:0]          zc, zlast;
   logic                   d_set, d_glyph, d_empty, d_skip;
   logic [15:0]            mag;
   logic [31:0]            prod;
   logic [7:0]             colbits, col_mask;
   logic                   y_on, y_last, x_on, x_last;

   function automatic coord_type clip_low(input coord_type c);
      return (c < 0) ? coord_type'(0) : c;
   endfunction

   // Command decode into a pixel area; lines and cleared rectangles are clipped at their low edges.
   always_comb begin
      px = coord_type'(req.pos_x);
      py = coord_type'(req.pos_y);
      ex = coord_type'(req.end_x);
      scale_w = 5'(req.scale);
      if (scale_w == 5'd0) begin
         zc = SB'(1);
      end else if (scale_w > 5'(pfgr_pkg::MAX_SCALE)) begin
         zc = SB'(pfgr_pkg::MAX_SCALE);
      end else begin
         zc = SB'(scale_w);
      end
      z5 = (coord_type'(zc) <<< 2) + coord_type'(zc);
      z7 = (coord_type'(zc) <<< 3) - coord_type'(zc);

      mag  = (req.sample_value < 0) ? 16'(-req.sample_value) : 16'(req.sample_value);
      prod = 32'(mag) * 32'(pfgr_pkg::PLOT_RECIP);
      if (req.sample_value >= pfgr_pkg::PLOT_HI_LIMIT) begin
         plot_row = coord_type'(pfgr_pkg::PLOT_HIGH);
      end else if (req.sample_value <= -pfgr_pkg::PLOT_LO_LIMIT) begin
         plot_row = coord_type'(pfgr_pkg::PLOT_LOW);
      end else if (req.sample_value < 0) begin
         plot_row = coord_type'(pfgr_pkg::PLOT_MID) - coord_type'(prod[31:16]);
      end else begin
         plot_row = coord_type'(pfgr_pkg::PLOT_MID) + coord_type'(prod[31:16]);
      end

      dx_lo   = px;
      dx_hi   = px;
      dy_lo   = py;
      dy_hi   = py;
      d_set   = 1'b1;
      d_glyph = 1'b0;
      d_skip  = 1'b0;
      case (req.kind)
         pfgr_pkg::KIND_PIXEL: begin
         end
         pfgr_pkg::KIND_GLYPH: begin
            dx_hi   = px + z5 - coord_type'(1);
            dy_hi   = py + z7 - coord_type'(1);
            d_glyph = 1'b1;
            d_skip  = (req.char_code == pfgr_pkg::CHAR_SPACE);
         end
         pfgr_pkg::KIND_LINE: begin
            dx_lo = clip_low(px);
            dx_hi = ex;
         end
         pfgr_pkg::KIND_CLEAR_RECT: begin
            dx_lo  = clip_low(px);
            dx_hi  = px + coord_type'(req.width) - coord_type'(1);
            dy_lo  = clip_low(py);
            dy_hi  = py + coord_type'(req.height) - coord_type'(1);
            d_set  = 1'b0;
         end
         pfgr_pkg::KIND_CLEAR_ALL: begin
            dx_lo = coord_type'(0);
            dx_hi = coord_type'(pfgr_pkg::SCREEN_WIDTH - 1);
            dy_lo = coord_type'(0);
            dy_hi = coord_type'(pfgr_pkg::SCREEN_HEIGHT - 1);
            d_set = 1'b0;
         end
         pfgr_pkg::KIND_PLOT: begin
            dy_lo = plot_row;
            dy_hi = plot_row;
         end
         default: begin
            d_skip = 1'b1;
         end
      endcase
      d_empty = d_skip || dx_lo > dx_hi || dy_lo > dy_hi || dx_hi < 0 || dy_hi < 0 ||
                dx_lo >= coord_type'(pfgr_pkg::SCREEN_WIDTH) ||
                dy_lo >= coord_type'(pfgr_pkg::SCREEN_HEIGHT);
   end

   // Column mask and address for the byte under the column walker.
   always_comb begin
      colbits = pfgr_pkg::glyph_column(code_ff, a_ff);
      for (int r = 0; r < 8; r++) begin
         col_mask[r] = rowmask_ff[r] & (~glyph_ff | colbits[rowfr_ff[r]]);
      end
      col_addr = AB'(page_ff) * AB'(pfgr_pkg::SCREEN_WIDTH) +
                 AB'(x_ff[pfgr_pkg::X_BITS-1:0]);
      zlast  = scale_ff - SB'(1);
      y_on   = (y_ff >= 0) && (y_ff < coord_type'(pfgr_pkg::SCREEN_HEIGHT));
      y_last = (y_ff == y_hi_ff) || (y_ff == coord_type'(pfgr_pkg::SCREEN_HEIGHT - 1));
      x_on   = (x_ff >= 0) && (x_ff < coord_type'(pfgr_pkg::SCREEN_WIDTH));
      x_last = (x_ff == x_hi_ff) || (x_ff == coord_type'(pfgr_pkg::SCREEN_WIDTH - 1));
   end

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      y_in         = y_ff;
      y_hi_in      = y_hi_ff;
      x_in         = x_ff;
      x_lo_in      = x_lo_ff;
      x_hi_in      = x_hi_ff;
      fr_in        = fr_ff;
      fsub_in      = fsub_ff;
      a_in         = a_ff;
      asub_in      = asub_ff;
      scale_in     = scale_ff;
      page_in      = page_ff;
      rows_done_in = rows_done_ff;
      glyph_in     = glyph_ff;
      set_in       = set_ff;
      code_in      = code_ff;
      rowmask_in   = rowmask_ff;
      rowfr_in     = rowfr_ff;
      rdidx_in     = rdidx_ff;
      rd_oob_in    = rd_oob_ff;
      wv_in        = 1'b0;
      wset_in      = wset_ff;
      wa_in        = wa_ff;
      wm_in        = wm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      mem_ra       = AB'(rdidx_ff);

      case (state_ff)
         S_INIT: begin
            init_cnt_in = init_cnt_ff + AB'(1);
            if (init_cnt_ff == AB'(pfgr_pkg::STORE_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               if (req.kind == pfgr_pkg::KIND_READ) begin
                  rdidx_in  = req.read_index;
                  rd_oob_in = 32'(req.read_index) >= 32'(pfgr_pkg::STORE_BYTES);
                  state_in  = S_READ;
               end else if (!d_empty) begin
                  y_in       = dy_lo;
                  y_hi_in    = dy_hi;
                  x_lo_in    = dx_lo;
                  x_hi_in    = dx_hi;
                  fr_in      = '0;
                  fsub_in    = '0;
                  scale_in   = d_glyph ? zc : SB'(1);
                  glyph_in   = d_glyph;
                  set_in     = d_set;
                  code_in    = req.char_code;
                  rowmask_in = '0;
                  state_in   = S_ROWS;
               end
            end
         end
         S_ROWS: begin
            if (y_on) begin
               rowmask_in[y_ff[2:0]] = 1'b1;
               rowfr_in[y_ff[2:0]]   = fr_ff;
               page_in               = y_ff[PB+2:3];
            end
            y_in = y_ff + coord_type'(1);
            if (fsub_ff == zlast) begin
               fsub_in = '0;
               fr_in   = fr_ff + 3'd1;
            end else begin
               fsub_in = fsub_ff + SB'(1);
            end
            if (y_on && (y_ff[2:0] == 3'd7 || y_last)) begin
               rows_done_in = y_last;
               x_in         = x_lo_ff;
               a_in         = '0;
               asub_in      = '0;
               state_in     = S_COLS;
            end
         end
         S_COLS: begin
            mem_ra = col_addr;
            if (x_on) begin
               wv_in   = 1'b1;
               wa_in   = col_addr;
               wm_in   = col_mask;
               wset_in = set_ff;
            end
            x_in = x_ff + coord_type'(1);
            if (asub_ff == zlast) begin
               asub_in = '0;
               a_in    = a_ff + 3'd1;
            end else begin
               asub_in = asub_ff + SB'(1);
            end
            if (x_last) begin
               rowmask_in = '0;
               state_in   = rows_done_ff ? S_DRAIN : S_ROWS;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_oob_ff ? 8'd0 : rd_data_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         wv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rowmask_ff   <= '0;
         rows_done_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         wv_ff        <= wv_in;
         rsp_valid_ff <= rsp_valid_in;
         rowmask_ff   <= rowmask_in;
         rows_done_ff <= rows_done_in;
      end
      y_ff        <= y_in;
      y_hi_ff     <= y_hi_in;
      x_ff        <= x_in;
      x_lo_ff     <= x_lo_in;
      x_hi_ff     <= x_hi_in;
      fr_ff       <= fr_in;
      fsub_ff     <= fsub_in;
      a_ff        <= a_in;
      asub_ff     <= asub_in;
      scale_ff    <= scale_in;
      page_ff     <= page_in;
      glyph_ff    <= glyph_in;
      set_ff      <= set_in;
      code_ff     <= code_in;
      rowfr_ff    <= rowfr_in;
      rdidx_ff    <= rdidx_in;
      rd_oob_ff   <= rd_oob_in;
      wset_ff     <= wset_in;
      wa_ff       <= wa_in;
      wm_ff       <= wm_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The write of a byte lands in the cycle after its read; the drain state keeps the
   // next command's first read behind the last write.
   always_comb begin
      mem_we = (state_ff == S_INIT) || wv_ff;
      mem_wa = (state_ff == S_INIT) ? init_cnt_ff : wa_ff;
      if (state_ff == S_INIT) begin
         mem_wd = '0;
      end else if (wset_ff) begin
         mem_wd = rd_data_ff | wm_ff;
      end else begin
         mem_wd = rd_data_ff & ~wm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pfgr_checker.sv =====
// Port-level checks for the page framebuffer renderer, bound to its top level.
// Depends on pfgr_pkg and on page_framebuffer_glyph_renderer.
`default_nettype none

module pfgr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [2:0] req_kind,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data
);

   // The framebuffer clearing pass keeps the block busy and silent after reset.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block ready or responding right after reset");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == pfgr_pkg::KIND_READ |=> !req_ready)
      else $error("block ready in the cycle after accepting a read");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind != pfgr_pkg::KIND_READ && !rsp_valid |=> !rsp_valid)
      else $error("result item appeared after a drawing command");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled result item changed or vanished");

endmodule

bind page_framebuffer_glyph_renderer pfgr_checker u_pfgr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_kind      (req.kind),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_read_data (rsp.read_data)
);

`default_nettype wire
